// ===== hdl/tec_pkg.sv =====
// ----------------------------------------------------------------------------
// tec_pkg
// Shared types, constants and the pattern distance function of the track
// element classifier.
// ----------------------------------------------------------------------------
package tec_pkg;

  localparam int SensorBits = 12;
  localparam int SumW       = SensorBits + 2;
  localparam int DiffW      = ((SensorBits > 12) ? SensorBits : 12) + 1;
  localparam int SqW        = 2 * DiffW;
  localparam int DistW      = SqW + 2;
  localparam int CfgDataW   = 15;
  localparam int CfgIdxW    = 3;

  // Sum thresholds of the classification, the sensor limits of the ring checks and the crossing dwell wrap.
  localparam int SumStraightLo   = 400;
  localparam int SumCurveLo      = 5000;
  localparam int SumCurveHi      = 9500;
  localparam int SumCrossConfirm = 10500;
  localparam int SumRingInLo     = 10000;
  localparam int SumRingInHi     = 11200;
  localparam int SumRingOutLo    = 11500;
  localparam int SumCrossLo      = 11000;
  localparam int RingInSlantMax  = 500;
  localparam int RingOutHorizMax = 1650;
  localparam int DwellWrap       = 500;

  // Squared distance limits of the pattern matches.
  localparam int LimConfirm = 150000;
  localparam int LimCross   = 130000;
  localparam int LimRing    = 120000;

  // Reference patterns: left horizontal in the low slot, right slanted on top.
  localparam logic [3:0][15:0] PatCross   = {16'd3634, 16'd3688, 16'd1965, 16'd2661};
  localparam logic [3:0][15:0] PatRingIn  = {16'd35,   16'd3577, 16'd3661, 16'd3699};
  localparam logic [3:0][15:0] PatRingOut = {16'd3564, 16'd3701, 16'd1512, 16'd3681};

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRingHoldTicks   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRingHoldRptMax  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCrossCheckTicks = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSteerThreshold  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLostLineLevel   = 3'd4;

  typedef enum logic [2:0] {
    ClsStraight  = 3'd0,
    ClsLeft      = 3'd1,
    ClsRight     = 3'd2,
    ClsRingIn    = 3'd3,
    ClsRingOut   = 3'd4,
    ClsForceStr  = 3'd5,
    ClsStop      = 3'd6
  } road_class_t;

  typedef struct packed {
    logic [6:0]  ring_hold_ticks;
    logic [6:0]  ring_hold_report_max;
    logic [8:0]  cross_check_ticks;
    logic [14:0] steer_threshold;
    logic [11:0] lost_line_level;
  } cfg_t;

  typedef logic [3:0][SensorBits-1:0] sens_t;

  // Features of one word, as handed from the front stage to the core.
  typedef struct packed {
    logic [SumW-1:0]  sum;
    logic [DistW-1:0] dist_cross;
    logic [DistW-1:0] dist_ring_in;
    logic [DistW-1:0] dist_ring_out;
    logic             err_ge;
    logic             err_le;
    logic             lost;
    logic             rs_low;
    logic             rh_low;
  } feat_t;

  function automatic logic [DistW-1:0] pat_dist(input sens_t s, input logic [3:0][15:0] pat);
    logic signed [DiffW-1:0] d;
    logic [SqW-1:0]          sq;
    logic [DistW-1:0]        acc;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      d   = $signed(DiffW'(s[k])) - $signed(DiffW'(pat[k]));
      sq  = $unsigned(SqW'(d) * SqW'(d));
      acc = acc + DistW'(sq);
    end
    return acc;
  endfunction

endpackage

// ===== hdl/tec_if.sv =====
// ----------------------------------------------------------------------------
// tec_in_if / tec_out_if
// Valid/ready channels for sensor words and classification words.
// ----------------------------------------------------------------------------
interface tec_in_if;
  logic                             valid;
  logic                             ready;
  logic [tec_pkg::SensorBits-1:0]   left_horizontal;
  logic [tec_pkg::SensorBits-1:0]   right_horizontal;
  logic [tec_pkg::SensorBits-1:0]   left_slanted;
  logic [tec_pkg::SensorBits-1:0]   right_slanted;
  logic signed [15:0]               steer_error;

  modport source (output valid, left_horizontal, right_horizontal, left_slanted,
                  right_slanted, steer_error, input ready);
  modport sink   (input valid, left_horizontal, right_horizontal, left_slanted,
                  right_slanted, steer_error, output ready);
endinterface

interface tec_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] road_class;
  logic [7:0] crossing_count;

  modport source (output valid, road_class, crossing_count, input ready);
  modport sink   (input valid, road_class, crossing_count, output ready);
endinterface

// ===== hdl/track_element_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// track_element_classifier_unit
// Classifies the track element from four inductor readings and a steering
// error, one word per control tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sensor word (four readings and the Q8.8 steering error)
//   and out_ch one result word (road class and crossing count), both with
//   valid/ready. A word is taken when valid and ready are high at a clock edge.
//   The cfg_ port writes register cfg_index with cfg_data when cfg_we is high;
//   write it only while no word is in flight.
//   A word accepted at a clock edge passes the input register, the feature
//   register (sum and squared pattern distances) and the result register,
//   in that order. One word is accepted every cycle while out_ch is not
//   stalled; the classifier core updates its state as each word enters the
//   result register, so back-to-back words flow at full rate.
//   Reset clears the track state and the pipeline and loads the register
//   defaults. When out_ch stalls, each stage holds its word and bubbles are
//   squeezed out, so in_ch keeps accepting until all three stages are full.
// ----------------------------------------------------------------------------
module track_element_classifier_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  tec_in_if.sink                         in_ch,
  tec_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tec_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [tec_pkg::CfgDataW-1:0]   cfg_data
);
  import tec_pkg::*;

  cfg_t  cfg_r;
  logic  feat_valid;
  logic  feat_ready;
  feat_t feat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_hold_ticks      <= 7'd120;
      cfg_r.ring_hold_report_max <= 7'd114;
      cfg_r.cross_check_ticks    <= 9'd20;
      cfg_r.steer_threshold      <= 15'd128;
      cfg_r.lost_line_level      <= 12'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgRingHoldTicks:   cfg_r.ring_hold_ticks      <= cfg_data[6:0];
        CfgRingHoldRptMax:  cfg_r.ring_hold_report_max <= cfg_data[6:0];
        CfgCrossCheckTicks: cfg_r.cross_check_ticks    <= cfg_data[8:0];
        CfgSteerThreshold:  cfg_r.steer_threshold      <= cfg_data[14:0];
        CfgLostLineLevel:   cfg_r.lost_line_level      <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  tec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .feat_valid (feat_valid),
    .feat       (feat),
    .feat_ready (feat_ready)
  );

  tec_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .feat_valid (feat_valid),
    .feat       (feat),
    .feat_ready (feat_ready),
    .out_ch     (out_ch)
  );

endmodule

// ===== hdl/tec_front.sv =====
// ----------------------------------------------------------------------------
// tec_front
// Input register and feature stage: sensor sum, squared distances to the
// three reference patterns and the threshold compares.
// ----------------------------------------------------------------------------
module tec_front (
  input  logic           clk,
  input  logic           rst_n,
  tec_in_if.sink         in_ch,
  input  tec_pkg::cfg_t  cfg,
  output logic           feat_valid,
  output tec_pkg::feat_t feat,
  input  logic           feat_ready
);
  import tec_pkg::*;

  logic               in_valid_r;
  sens_t              sens_r;
  logic signed [15:0] err_r;
  logic               feat_valid_r;
  feat_t              feat_r;
  feat_t              feat_nxt;

  logic               s2_free;
  logic               s1_adv;
  logic signed [16:0] err_x;
  logic signed [16:0] thr_x;

  assign s2_free     = !feat_valid_r || feat_ready;
  assign s1_adv      = in_valid_r && s2_free;
  assign in_ch.ready = !in_valid_r || s2_free;

  assign err_x = 17'(err_r);
  assign thr_x = $signed({2'b00, cfg.steer_threshold});

  always_comb begin
    feat_nxt.sum = SumW'(sens_r[0]) + SumW'(sens_r[1]) + SumW'(sens_r[2])
                 + SumW'(sens_r[3]);
    feat_nxt.dist_cross    = pat_dist(sens_r, PatCross);
    feat_nxt.dist_ring_in  = pat_dist(sens_r, PatRingIn);
    feat_nxt.dist_ring_out = pat_dist(sens_r, PatRingOut);
    feat_nxt.err_ge        = err_x >= thr_x;
    feat_nxt.err_le        = err_x <= -thr_x;
    feat_nxt.lost          = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (32'(sens_r[k]) <= 32'(cfg.lost_line_level)) begin
        feat_nxt.lost = 1'b1;
      end
    end
    feat_nxt.rs_low = 32'(sens_r[3]) <= 32'(RingInSlantMax);
    feat_nxt.rh_low = 32'(sens_r[1]) <= 32'(RingOutHorizMax);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      feat_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (s2_free) begin
        feat_valid_r <= s1_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sens_r <= {in_ch.right_slanted, in_ch.left_slanted,
                 in_ch.right_horizontal, in_ch.left_horizontal};
      err_r  <= in_ch.steer_error;
    end
    if (s1_adv) begin
      feat_r <= feat_nxt;
    end
  end

  assign feat_valid = feat_valid_r;
  assign feat       = feat_r;

endmodule

// ===== hdl/tec_core.sv =====
// ----------------------------------------------------------------------------
// tec_core
// Track state (ring hold, ring flags, crossing dwell and count) and the
// classification priority chain, with the result register.
// ----------------------------------------------------------------------------
module tec_core (
  input  logic           clk,
  input  logic           rst_n,
  input  tec_pkg::cfg_t  cfg,
  input  logic           feat_valid,
  input  tec_pkg::feat_t feat,
  output logic           feat_ready,
  tec_out_if.source      out_ch
);
  import tec_pkg::*;

  logic        out_valid_r;
  road_class_t road_class_r;
  road_class_t cls;
  logic [6:0]  ring_hold_r,  ring_hold_nxt;
  logic [8:0]  cross_dwell_r, cross_dwell_nxt;
  logic        cross_pending_r, cross_pending_nxt;
  logic        in_ring_r, in_ring_nxt;
  logic        left_ring_r, left_ring_nxt;
  logic [7:0]  cross_total_r, cross_total_nxt;

  logic        take;
  logic [6:0]  hold_dec;
  logic [8:0]  dwell_inc;
  logic [31:0] sum_x;
  logic        is_straight, is_curve, is_ring_in, is_ring_out, is_cross, is_confirm;

  assign feat_ready = !out_valid_r || out_ch.ready;
  assign take       = feat_valid && feat_ready;
  assign hold_dec   = ring_hold_r - 7'd1;
  assign sum_x      = 32'(feat.sum);

  assign is_straight = sum_x > 32'(SumStraightLo) && sum_x < 32'(SumCurveLo);
  assign is_curve    = sum_x >= 32'(SumCurveLo) && sum_x < 32'(SumCurveHi);
  assign is_ring_in  = sum_x >= 32'(SumRingInLo) && sum_x <= 32'(SumRingInHi)
                     && feat.rs_low && feat.dist_ring_in <= DistW'(LimRing);
  assign is_ring_out = sum_x >= 32'(SumRingOutLo) && feat.rh_low
                     && feat.dist_ring_out <= DistW'(LimRing);
  assign is_cross    = sum_x >= 32'(SumCrossLo) && feat.dist_cross <= DistW'(LimCross);
  assign is_confirm  = sum_x >= 32'(SumCrossConfirm)
                     && !(feat.dist_cross <= DistW'(LimConfirm));

  always_comb begin
    ring_hold_nxt     = ring_hold_r;
    cross_dwell_nxt   = cross_dwell_r;
    cross_pending_nxt = cross_pending_r;
    in_ring_nxt       = in_ring_r;
    left_ring_nxt     = left_ring_r;
    cross_total_nxt   = cross_total_r;
    cls               = ClsStraight;
    dwell_inc         = '0;

    if (ring_hold_r != 7'd0) begin
      ring_hold_nxt = hold_dec;
    end

    // While the hold counter runs inside the report window, ring entry is
    // reported and nothing else moves.
    if (ring_hold_r != 7'd0 && hold_dec != 7'd0 && hold_dec <= cfg.ring_hold_report_max) begin
      cls = ClsRingIn;
    end else begin
      if (cross_dwell_r >= cfg.cross_check_ticks) begin
        if (cross_pending_r && is_confirm) begin
          if (cross_total_r != 8'hFF) begin
            cross_total_nxt = cross_total_r + 8'd1;
          end
          cross_pending_nxt = 1'b0;
        end
        cross_dwell_nxt = '0;
      end
      dwell_inc = cross_dwell_nxt + 9'd1;

      if (is_straight) begin
        cls = ClsStraight;
      end else if (is_curve && feat.err_ge) begin
        cls = ClsLeft;
      end else if (is_curve && feat.err_le) begin
        cls = ClsRight;
      end else if (is_ring_in) begin
        ring_hold_nxt = cfg.ring_hold_ticks;
        if (!left_ring_r) begin
          in_ring_nxt = 1'b1;
          cls         = ClsRingIn;
        end
      end else if (is_ring_out) begin
        if (in_ring_r) begin
          left_ring_nxt = 1'b1;
          cls           = ClsRingOut;
        end
      end else if (is_cross) begin
        in_ring_nxt       = 1'b0;
        left_ring_nxt     = 1'b0;
        cross_pending_nxt = 1'b1;
        cross_dwell_nxt   = (32'(dwell_inc) >= 32'(DwellWrap)) ? 9'd0 : dwell_inc;
        cls               = ClsForceStr;
      end else if (feat.lost) begin
        cls = ClsStop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      ring_hold_r     <= '0;
      cross_dwell_r   <= '0;
      cross_pending_r <= 1'b0;
      in_ring_r       <= 1'b0;
      left_ring_r     <= 1'b0;
      cross_total_r   <= '0;
    end else begin
      if (feat_ready) begin
        out_valid_r <= feat_valid;
      end
      if (take) begin
        ring_hold_r     <= ring_hold_nxt;
        cross_dwell_r   <= cross_dwell_nxt;
        cross_pending_r <= cross_pending_nxt;
        in_ring_r       <= in_ring_nxt;
        left_ring_r     <= left_ring_nxt;
        cross_total_r   <= cross_total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      road_class_r <= cls;
    end
  end

  // The count only moves when a new word enters the result register, so the
  // state register doubles as the count field of the waiting word.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.road_class     = road_class_r;
  assign out_ch.crossing_count = cross_total_r;

endmodule

// ===== hdl/tec_checker.sv =====
// ----------------------------------------------------------------------------
// tec_checker
// Port-level checks of the track element classifier, bound to the top level.
// ----------------------------------------------------------------------------
module tec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] road_class,
  input logic [7:0] crossing_count
);
  import tec_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(road_class) && $stable(crossing_count))
    else $error("result word changed while stalled");

  // The pipeline can only refuse input when a result is waiting.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input refused with no result waiting");

  // The crossing count never goes down between successive result words.
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && $past(rst_n) |-> crossing_count >= $past(crossing_count))
    else $error("crossing count decreased");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind track_element_classifier_unit tec_checker u_tec_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .road_class     (out_ch.road_class),
  .crossing_count (out_ch.crossing_count)
);
